/* rtl/core/lmtf_pkg.sv */
// Shared codes, register map and status types for the move-to-front key cache.
package lmtf_pkg;

    // Request kinds
    localparam logic [1:0] KIND_OPEN    = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;

    // Register map
    localparam int         PADDR_W       = 2;
    localparam logic [1:0] ADDR_MAX_OPEN = 2'd0;
    localparam logic [4:0] MAX_OPEN_RST  = 5'd16;

    // Completion status from the walker to the top level
    typedef struct packed {
        logic done;
        logic hit;
        logic evicted;
    } lmtf_flags_t;

endpackage

/* rtl/core/lmtf_walk.sv */
// Key memory and the sequencer that walks it with one shared key comparator.
module lmtf_walk #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [1:0]                 kind,
    input  logic [KEY_WIDTH-1:0]       key,
    input  logic [$clog2(DEPTH+1)-1:0] limit,
    output logic                       busy,
    output lmtf_pkg::lmtf_flags_t      flags,
    output logic [KEY_WIDTH-1:0]       evicted_key,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    state_t                 state_reg,   state_next;
    logic [1:0]             kind_reg,    kind_next;
    logic [KEY_WIDTH-1:0]   key_reg,     key_next;
    logic [CW-1:0]          cnt_reg,     cnt_next;
    logic [CW-1:0]          ridx_reg,    ridx_next;
    logic [CW-1:0]          cidx_reg,    cidx_next;
    logic                   pend_reg,    pend_next;
    logic                   evict_reg,   evict_next;
    logic                   found_reg,   found_next;
    logic [KEY_WIDTH-1:0]   evk_reg,     evk_next;
    logic                   done_reg,    done_next;
    logic                   hit_reg,     hit_next;
    logic                   ev_reg,      ev_next;
    logic [KEY_WIDTH-1:0]   evk_out_reg, evk_out_next;

    // key memory, one write and one registered read port
    logic [KEY_WIDTH-1:0]   mem [DEPTH];
    logic [KEY_WIDTH-1:0]   rdata_reg;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [KEY_WIDTH-1:0]   wr_data;
    logic [AW-1:0]          raddr;

    logic                   match;
    logic [CW-1:0]          cidx_inc;
    logic                   last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[raddr];
    end

    assign match    = (rdata_reg == key_reg);
    assign cidx_inc = cidx_reg + CW'(1);
    assign last     = (cidx_inc == cnt_reg);
    assign raddr    = ridx_reg[AW-1:0];

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        cidx_next    = cidx_reg;
        pend_next    = pend_reg;
        evict_next   = evict_reg;
        found_next   = found_reg;
        evk_next     = evk_reg;
        done_next    = 1'b0;
        hit_next     = hit_reg;
        ev_next      = ev_reg;
        evk_out_next = evk_out_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = rdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    key_next   = key;
                    ridx_next  = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    evict_next = (cnt_reg >= limit) && (cnt_reg != '0);
                    if ((kind == lmtf_pkg::KIND_OPEN || kind == lmtf_pkg::KIND_RELEASE)
                        && cnt_reg != '0)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_WALK:
            begin
                // read side runs one entry ahead of the compare
                cidx_next = ridx_reg;
                if (ridx_reg < cnt_reg)
                begin
                    ridx_next = ridx_reg + CW'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (kind_reg == lmtf_pkg::KIND_OPEN)
                    begin
                        if (match)
                        begin
                            found_next = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            // shift toward the back; the dropped tail is not copied
                            if (!(evict_reg && last))
                            begin
                                wr_en   = 1'b1;
                                wr_addr = AW'(cidx_inc);
                            end
                            if (last)
                            begin
                                evk_next   = rdata_reg;
                                state_next = ST_FINISH;
                            end
                        end
                    end
                    else
                    begin
                        // release: close the gap behind the matching entry
                        if (match && !found_reg)
                        begin
                            found_next = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = AW'(cidx_reg - CW'(1));
                        end
                        if (last)
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                state_next   = ST_IDLE;
                done_next    = 1'b1;
                hit_next     = found_reg;
                ev_next      = 1'b0;
                evk_out_next = '0;
                case (kind_reg)
                    lmtf_pkg::KIND_OPEN:
                    begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = key_reg;
                        if (!found_reg)
                        begin
                            cnt_next = evict_reg ? cnt_reg : cnt_reg + CW'(1);
                            if (evict_reg)
                            begin
                                ev_next      = 1'b1;
                                evk_out_next = evk_reg;
                            end
                        end
                    end
                    lmtf_pkg::KIND_RELEASE:
                    begin
                        if (found_reg)
                        begin
                            cnt_next = cnt_reg - CW'(1);
                        end
                    end
                    lmtf_pkg::KIND_CLEAR:
                    begin
                        cnt_next = '0;
                    end
                    default:
                    begin
                        cnt_next = cnt_reg;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            ridx_reg    <= '0;
            cidx_reg    <= '0;
            pend_reg    <= 1'b0;
            evict_reg   <= 1'b0;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            ev_reg      <= 1'b0;
            evk_out_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ridx_reg    <= ridx_next;
            cidx_reg    <= cidx_next;
            pend_reg    <= pend_next;
            evict_reg   <= evict_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            ev_reg      <= ev_next;
            evk_out_reg <= evk_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        evk_reg     <= evk_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign flags.done    = done_reg;
    assign flags.hit     = hit_reg;
    assign flags.evicted = ev_reg;
    assign evicted_key   = evk_out_reg;
    assign count         = cnt_reg;

endmodule

/* rtl/core/lru_move_to_front_cache.sv */
// Top level of the move-to-front LRU key cache: APB register, limit clamp, result ports.
//
// Usage:
//   Request channel: drive kind and key with start high; the item is taken at the
//   clock edge where start is high and busy is low. kind selects open (lookup and
//   move to front), release (remove one key) or clear (empty the list).
//   Result channel: done is high for exactly one cycle per item, together with hit,
//   evicted, evicted_key and occupancy. The receiver cannot stall; sample on done.
//   Sequencing: open and release walk the list once through the key memory's single
//   read port with one shared comparator, so an item's run grows with the keys held
//   and an open hit ends the walk early. Clear, an empty list and unused kinds skip
//   the walk. busy drops in the cycle done is shown, so the next item can be taken
//   right then.
//   Configuration: max_open at byte address 0 over APB, to be written only while
//   idle (not enforced by the block). Zero acts as one, values above DEPTH act as DEPTH.
//   Reset: the list is empty and max_open returns to 16. The key memory itself is
//   not cleared; only entries below the occupancy count are compared.
module lru_move_to_front_cache #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lmtf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // request
    input  logic                         start,
    input  logic [1:0]                   kind,
    input  logic [31:0]                  key,
    output logic                         busy,
    // result
    output logic                         done,
    output logic                         hit,
    output logic                         evicted,
    output logic [31:0]                  evicted_key,
    output logic [4:0]                   occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [4:0]                 max_open_reg;
    logic [CW-1:0]              limit;
    lmtf_pkg::lmtf_flags_t      flags;
    logic [KEY_WIDTH-1:0]       evk;
    logic [CW-1:0]              count;

    // register write at the APB access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_open_reg <= lmtf_pkg::MAX_OPEN_RST;
        end
        else if (psel && penable && pwrite && paddr == lmtf_pkg::ADDR_MAX_OPEN)
        begin
            max_open_reg <= pwdata[4:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == lmtf_pkg::ADDR_MAX_OPEN) ? 32'(max_open_reg) : '0;

    // clamp the limit into 1..DEPTH
    always_comb
    begin
        if (max_open_reg == 5'd0)
        begin
            limit = CW'(1);
        end
        else if (32'(max_open_reg) > DEPTH)
        begin
            limit = CW'(DEPTH);
        end
        else
        begin
            limit = CW'(max_open_reg);
        end
    end

    lmtf_walk #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .kind        (kind),
        .key         (KEY_WIDTH'(key)),
        .limit       (limit),
        .busy        (busy),
        .flags       (flags),
        .evicted_key (evk),
        .count       (count)
    );

    assign done        = flags.done;
    assign hit         = flags.hit;
    assign evicted     = flags.evicted;
    assign evicted_key = 32'(evk);
    assign occupancy   = 5'(count);

endmodule

/* rtl/core/lmtf_checker.sv */
// Port-level checks for the move-to-front LRU key cache, bound to the top level.
module lmtf_checker #(
    parameter int DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        hit,
    input logic        evicted,
    input logic [31:0] evicted_key,
    input logic [4:0]  occupancy
);

    // an accepted item must make the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

    // a result only ends a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
    else $error("result strobe without a preceding busy period");

    // eviction only on a miss
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
    else $error("hit and eviction in the same result");

    // dropped key is zero when nothing was dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted) |-> (evicted_key == 32'd0))
    else $error("evicted key nonzero without eviction");

    // an eviction comes with a nonzero occupancy no larger than DEPTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (occupancy != 5'd0 && 32'(occupancy) <= DEPTH))
    else $error("eviction with bad occupancy");

endmodule

bind lru_move_to_front_cache lmtf_checker #(
    .DEPTH (DEPTH)
) u_lmtf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .hit         (hit),
    .evicted     (evicted),
    .evicted_key (evicted_key),
    .occupancy   (occupancy)
);
